FILE: rtl/core/frp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// frp_pkg: shared types and constants of the frame receive parser
// Widths, phase codes, result event codes, port structs and the CRC byte step.
// ---------------------------------------------------------------------------
package frp_pkg;

   localparam int BufDepth   = 256;
   localparam int AddrW      = $clog2(BufDepth);
   localparam int PosW       = AddrW + 1;
   localparam int PayloadMax = ((BufDepth - 9) < 255) ? (BufDepth - 9) : 255;

   localparam logic [1:0] EV_FRAME = 2'd0;
   localparam logic [1:0] EV_READ  = 2'd1;
   localparam logic [1:0] EV_DROP  = 2'd2;

   localparam logic [1:0] CSR_HEADER = 2'd0;
   localparam logic [1:0] CSR_TYPE_A = 2'd1;
   localparam logic [1:0] CSR_TYPE_B = 2'd2;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER, PH_TYPE, PH_TOPIC, PH_SIZE, PH_CONTENT, PH_CRC
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_PARSE, ST_PWAIT, ST_OUT
   } state_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  frame_type;
      logic [15:0] frame_topic;
      logic [7:0]  payload_length;
      logic [7:0]  payload_byte;
   } rsp_type;

   // control from the sequencer to the parser datapath
   typedef struct packed {
      logic step;
      logic rst;
   } pctl_type;

   // parser report back to the sequencer
   typedef struct packed {
      logic       good;
      logic       restart;
      logic [PosW-1:0] restart_pos;
   } pstat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/frame_receive_parser_crc16.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// frame_receive_parser_crc16: length-prefixed frame receiver with CRC-16 check
// Buffers received bytes in a ring and parses header/type/topic/size/payload/CRC.
// ---------------------------------------------------------------------------
// A word with func 0 pushes a received byte into a 256-byte ring; the parser
// then walks the unparsed ring bytes, each by a ring memory read and then a
// parse, and answers with a frame event when a frame passes its CRC, or
// nothing; it stops early at such a frame. Normally one byte is parsed per
// push, more after a mismatch rescans from one byte past the frame start. A
// push into a full ring answers with a drop event. A word with func 1 reads
// the payload store through the READ and OUT states and answers.
// Results wait in an output register until taken.
module frame_receive_parser_crc16 (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire frp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output frp_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   localparam int PosW  = frp_pkg::PosW;
   localparam int AddrW = frp_pkg::AddrW;

   frp_pkg::state_type state_ff, state_in;
   logic [PosW-1:0] wpos_ff, wpos_in, fpos_ff, fpos_in, spos_ff, spos_in;
   logic [15:0] hval_ff;
   logic [7:0]  tca_ff, tcb_ff, ridx_ff, ridx_in;
   frp_pkg::rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;
   logic accept, full, ring_we;
   logic [PosW-1:0] used;
   logic [7:0] ring_q, pl_q, ptype, plen;
   logic [15:0] ptopic;
   frp_pkg::pctl_type pctl;
   frp_pkg::pstat_type pstat;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == frp_pkg::ST_IDLE) && !rv_ff;
   assign accept    = req_valid && req_ready;
   assign used      = wpos_ff - fpos_ff;
   assign full      = used[PosW-1];
   assign ring_we   = accept && req_data.func == frp_pkg::FUNC_PUSH && !full;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   frp_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wpos_ff[AddrW-1:0]),
      .wr_data (req_data.data_byte),
      .rd_addr (spos_ff[AddrW-1:0]),
      .rd_data (ring_q)
   );

   frp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .ctl          (pctl),
      .byte_in      (ring_q),
      .start_pos    (fpos_ff),
      .next_scan    (spos_ff),
      .header_value (hval_ff),
      .type_code_a  (tca_ff),
      .type_code_b  (tcb_ff),
      .pl_rd_addr   (ridx_ff),
      .pl_rd_data   (pl_q),
      .stat         (pstat),
      .type_seen    (ptype),
      .topic_word   (ptopic),
      .length_lo    (plen)
   );

   always_comb begin
      state_in = state_ff;
      wpos_in  = wpos_ff;
      fpos_in  = fpos_ff;
      spos_in  = spos_ff;
      ridx_in  = ridx_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff && !rsp_ready;
      pctl     = '0;
      unique case (state_ff)
         frp_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               if (req_data.func == frp_pkg::FUNC_READ) begin
                  ridx_in  = req_data.read_index;
                  state_in = frp_pkg::ST_READ;
               end else if (full) begin
                  rsp_in.event_res = frp_pkg::EV_DROP;
                  rv_in = 1'b1;
               end else begin
                  wpos_in  = wpos_ff + PosW'(1);
                  state_in = frp_pkg::ST_PARSE;
               end
            end
         end
         frp_pkg::ST_READ: state_in = frp_pkg::ST_OUT;
         frp_pkg::ST_OUT: begin
            rsp_in.event_res    = frp_pkg::EV_READ;
            rsp_in.payload_byte = pl_q;
            rv_in    = 1'b1;
            state_in = frp_pkg::ST_IDLE;
         end
         frp_pkg::ST_PARSE: begin
            // issue ring read at scan position, or finish when caught up
            if (spos_ff == wpos_ff) state_in = frp_pkg::ST_IDLE;
            else begin
               spos_in  = spos_ff + PosW'(1);
               state_in = frp_pkg::ST_PWAIT;
            end
         end
         frp_pkg::ST_PWAIT: begin
            pctl.step = 1'b1;
            state_in  = frp_pkg::ST_PARSE;
            if (pstat.good || pstat.restart) begin
               fpos_in = pstat.restart_pos;
               spos_in = pstat.restart_pos;
            end
            if (pstat.good) begin
               rsp_in.event_res      = frp_pkg::EV_FRAME;
               rsp_in.frame_type     = ptype;
               rsp_in.frame_topic    = ptopic;
               rsp_in.payload_length = plen;
               rv_in    = 1'b1;
               state_in = frp_pkg::ST_IDLE;
            end
         end
         default: state_in = frp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frp_pkg::ST_IDLE;
         wpos_ff  <= '0;
         fpos_ff  <= '0;
         spos_ff  <= '0;
         rv_ff    <= 1'b0;
         hval_ff  <= 16'h0000;
         tca_ff   <= 8'h00;
         tcb_ff   <= 8'h01;
      end else begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         fpos_ff  <= fpos_in;
         spos_ff  <= spos_in;
         rv_ff    <= rv_in;
         if (csr_valid) begin
            unique case (csr_index)
               frp_pkg::CSR_HEADER: hval_ff <= csr_wdata;
               frp_pkg::CSR_TYPE_A: tca_ff  <= csr_wdata[7:0];
               frp_pkg::CSR_TYPE_B: tcb_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= ridx_in;
      rsp_ff  <= rsp_in;
   end
endmodule
`default_nettype wire

FILE: rtl/core/frp_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// frp_ring: received byte ring buffer
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module frp_ring (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [frp_pkg::AddrW-1:0] wr_addr,
   input  wire logic [7:0]               wr_data,
   input  wire logic [frp_pkg::AddrW-1:0] rd_addr,
   output logic [7:0]                    rd_data
);
   logic [7:0] mem [frp_pkg::BufDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/frp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// frp_parser: per-byte frame field parser
// Consumes one ring byte per step, tracks phase, fields and CRC, and writes
// payload bytes into the payload store.
// ---------------------------------------------------------------------------
module frp_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire frp_pkg::pctl_type       ctl,
   input  wire logic [7:0]              byte_in,
   input  wire logic [frp_pkg::PosW-1:0] start_pos,
   input  wire logic [frp_pkg::PosW-1:0] next_scan,
   input  wire logic [15:0]             header_value,
   input  wire logic [7:0]              type_code_a,
   input  wire logic [7:0]              type_code_b,
   input  wire logic [7:0]              pl_rd_addr,
   output logic [7:0]                   pl_rd_data,
   output frp_pkg::pstat_type           stat,
   output logic [7:0]                   type_seen,
   output logic [15:0]                  topic_word,
   output logic [7:0]                   length_lo
);
   frp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  left_ff, left_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] hdr_ff, hdr_in, top_ff, top_in, len_ff, len_in, rcrc_ff, rcrc_in;
   logic [7:0]  typ_ff, typ_in, cnt_ff, cnt_in;
   logic [1:0]  left_dec;
   logic [15:0] crc_next;
   logic        pl_we;
   logic [7:0]  pl_mem [256];

   function automatic logic [15:0] shift_in(input logic [15:0] w, input logic [1:0] l,
                                            input logic [7:0] b);
      return (l == 2'd1) ? {b, w[7:0]} : {w[15:8], b};
   endfunction

   assign left_dec = left_ff - 2'd1;
   assign crc_next = frp_pkg::crc_byte(crc_ff, byte_in);

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      crc_in   = crc_ff;
      hdr_in   = hdr_ff;
      top_in   = top_ff;
      len_in   = len_ff;
      rcrc_in  = rcrc_ff;
      typ_in   = typ_ff;
      cnt_in   = cnt_ff;
      pl_we    = 1'b0;
      stat     = '0;
      if (ctl.step) begin
         unique case (phase_ff)
            frp_pkg::PH_HEADER: begin
               left_in = left_dec;
               hdr_in  = shift_in(hdr_ff, left_dec, byte_in);
               crc_in  = crc_next;
               if (left_dec == 2'd0) begin
                  if (hdr_in == header_value) phase_in = frp_pkg::PH_TYPE;
                  else stat.restart = 1'b1;
               end
            end
            frp_pkg::PH_TYPE: begin
               if (byte_in == type_code_a || byte_in == type_code_b) begin
                  typ_in   = byte_in;
                  left_in  = 2'd2;
                  phase_in = frp_pkg::PH_TOPIC;
                  crc_in   = crc_next;
               end else begin
                  stat.restart = 1'b1;
               end
            end
            frp_pkg::PH_TOPIC: begin
               left_in = left_dec;
               top_in  = shift_in(top_ff, left_dec, byte_in);
               crc_in  = crc_next;
               if (left_dec == 2'd0) begin
                  left_in  = 2'd2;
                  phase_in = frp_pkg::PH_SIZE;
               end
            end
            frp_pkg::PH_SIZE: begin
               left_in = left_dec;
               len_in  = shift_in(len_ff, left_dec, byte_in);
               crc_in  = crc_next;
               if (left_dec == 2'd0) begin
                  if (len_in > 16'(frp_pkg::PayloadMax)) begin
                     stat.restart = 1'b1;
                  end else if (len_in == 16'd0) begin
                     left_in  = 2'd2;
                     phase_in = frp_pkg::PH_CRC;
                  end else begin
                     cnt_in   = 8'd0;
                     phase_in = frp_pkg::PH_CONTENT;
                  end
               end
            end
            frp_pkg::PH_CONTENT: begin
               pl_we  = 1'b1;
               cnt_in = cnt_ff + 8'd1;
               crc_in = crc_next;
               if ({8'h00, cnt_in} >= len_ff) begin
                  left_in  = 2'd2;
                  phase_in = frp_pkg::PH_CRC;
                  cnt_in   = 8'd0;
               end
            end
            frp_pkg::PH_CRC: begin
               left_in = left_dec;
               rcrc_in = shift_in(rcrc_ff, left_dec, byte_in);
               if (left_dec == 2'd0) begin
                  if (rcrc_in == {crc_ff[7:0], crc_ff[15:8]}) stat.good = 1'b1;
                  else stat.restart = 1'b1;
               end
            end
            default: stat.restart = 1'b1;
         endcase
      end
      stat.restart_pos = stat.good ? next_scan : start_pos + frp_pkg::PosW'(1);
      if (ctl.rst || stat.good || stat.restart) begin
         phase_in = frp_pkg::PH_HEADER;
         left_in  = 2'd2;
         crc_in   = 16'hFFFF;
         cnt_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= frp_pkg::PH_HEADER;
         left_ff  <= 2'd2;
         crc_ff   <= 16'hFFFF;
         hdr_ff   <= '0;
         top_ff   <= '0;
         len_ff   <= '0;
         rcrc_ff  <= '0;
         typ_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         crc_ff   <= crc_in;
         hdr_ff   <= hdr_in;
         top_ff   <= top_in;
         len_ff   <= len_in;
         rcrc_ff  <= rcrc_in;
         typ_ff   <= typ_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         pl_mem[cnt_ff] <= byte_in;
      end
      pl_rd_data <= pl_mem[pl_rd_addr];
   end

   assign type_seen  = typ_ff;
   assign topic_word = top_ff;
   assign length_lo  = len_ff[7:0];
endmodule
`default_nettype wire
